>>> rtl/zsse_pkg.sv
// Package for the zlib stored-stream encoder: constants, slot codes and the item descriptor.
package zsse_pkg;

    localparam int unsigned DATA_W   = 8;
    localparam int unsigned LEN_W    = 32;
    localparam int unsigned SUM_W    = 16;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;
    localparam int unsigned NUM_SLOTS = 12;

    localparam logic [DATA_W-1:0] ZLIB_CMF  = 8'h78;
    localparam logic [DATA_W-1:0] ZLIB_FLG  = 8'h01;
    localparam logic [SUM_W-1:0]  BLOCK_MAX = 16'd65535;
    localparam logic [SUM_W:0]    ADLER_MOD = 17'd65521;

    // register index, taken from paddr[2]
    localparam logic REG_STREAM_LENGTH = 1'b0;

    // output slot codes, in the order they leave the block
    typedef enum logic [3:0] {
        SLOT_CMF      = 4'd0,
        SLOT_FLG      = 4'd1,
        SLOT_BFINAL   = 4'd2,
        SLOT_LEN_LO   = 4'd3,
        SLOT_LEN_HI   = 4'd4,
        SLOT_NLEN_LO  = 4'd5,
        SLOT_NLEN_HI  = 4'd6,
        SLOT_DATA     = 4'd7,
        SLOT_S2_HI    = 4'd8,
        SLOT_S2_LO    = 4'd9,
        SLOT_S1_HI    = 4'd10,
        SLOT_S1_LO    = 4'd11
    } slot_t;

    typedef struct packed {
        logic              bfinal;
        logic [SUM_W-1:0]  blk_len;
        logic [DATA_W-1:0] data;
        logic [SUM_W-1:0]  sum_high;
        logic [SUM_W-1:0]  sum_low;
    } desc_t;

endpackage

>>> rtl/zlib_stored_stream_encoder_unit.sv
// Top level of the zlib stored-stream encoder with running Adler-32.
//
// Wraps a raw byte stream of programmed length (stream_length, APB offset 0x0,
// a value of 0 acts as 1) in a zlib stream of stored DEFLATE blocks of up to
// 65535 bytes. Each accepted input transaction produces 1 to 12 output
// transactions: the zlib header 0x78 0x01 before the first byte of a stream,
// a five-byte block header (BFINAL, LEN, NLEN) where a block opens, the data
// byte itself, and the Adler-32 trailer (s2 then s1, big-endian) after the
// last byte, at which point the stream state returns to its reset values.
// m_run_last marks the last output byte of each input, m_stream_end the final
// trailer byte. All per-item work (block sizing, Adler update, end test) is
// done in the cycle of acceptance and parked in a descriptor register; a
// sequencer then drains one byte per cycle into the output register while
// m_ready allows. An input yielding a single byte is therefore sustained at
// one transaction per cycle while m_ready stays high; an input yielding
// more bytes holds off the next input until its last byte goes out, the
// output port being the limiting resource. stream_length may only be written
// while no transaction is in flight.
module zlib_stored_stream_encoder_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [zsse_pkg::PADDR_W-1:0]  paddr,
    input  logic [zsse_pkg::PDATA_W-1:0]  pwdata,
    output logic [zsse_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    // raw byte input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [zsse_pkg::DATA_W-1:0]   s_data_byte,
    // zlib byte output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [zsse_pkg::DATA_W-1:0]   m_out_byte,
    output logic                          m_run_last,
    output logic                          m_stream_end
);

    localparam int unsigned NS = zsse_pkg::NUM_SLOTS;

    // configuration register
    logic [zsse_pkg::LEN_W-1:0]  stream_length_reg;

    // stream state
    logic [zsse_pkg::LEN_W-1:0]  bytes_taken_reg, bytes_taken_next;
    logic [zsse_pkg::SUM_W-1:0]  block_left_reg, block_left_next;
    logic [zsse_pkg::SUM_W-1:0]  sum_low_reg, sum_low_next;
    logic [zsse_pkg::SUM_W-1:0]  sum_high_reg, sum_high_next;

    // descriptor of the item being drained
    logic [NS-1:0]               mask_reg, mask_next;
    zsse_pkg::desc_t             desc_reg, desc_next;

    // output register
    logic                        m_valid_reg;
    logic [zsse_pkg::DATA_W-1:0] m_out_byte_reg;
    logic                        m_run_last_reg;
    logic                        m_stream_end_reg;

    // per-item combinational terms
    logic                        accept;
    logic                        cfg_write;
    logic [zsse_pkg::LEN_W-1:0]  eff_len;
    logic [zsse_pkg::LEN_W-1:0]  remain;
    logic                        hdr_due;
    logic                        blk_due;
    logic                        bfinal;
    logic [zsse_pkg::SUM_W-1:0]  blk_len;
    logic [zsse_pkg::SUM_W:0]    low_sum;
    logic [zsse_pkg::SUM_W-1:0]  low_mod;
    logic [zsse_pkg::SUM_W:0]    high_sum;
    logic [zsse_pkg::SUM_W-1:0]  high_mod;
    logic [zsse_pkg::LEN_W-1:0]  taken_inc;
    logic                        stream_done;
    logic [NS-1:0]               new_mask;

    // drain side
    logic                        out_free;
    logic                        emit;
    logic [NS-1:0]               low_bit;
    logic                        last_slot;
    zsse_pkg::slot_t             slot;
    logic [zsse_pkg::DATA_W-1:0] slot_byte;

    // ------------------------------------------------------------------
    // APB: single register, written on the access phase
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == zsse_pkg::REG_STREAM_LENGTH);
    assign prdata    = (paddr[2] == zsse_pkg::REG_STREAM_LENGTH)
                       ? stream_length_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stream_length_reg <= zsse_pkg::LEN_W'(1);
        end else if (cfg_write) begin
            stream_length_reg <= pwdata;
        end
    end

    // ------------------------------------------------------------------
    // Item evaluation: everything for one input byte in the accept cycle
    // ------------------------------------------------------------------
    always_comb begin
        eff_len = (stream_length_reg == '0) ? zsse_pkg::LEN_W'(1) : stream_length_reg;
        hdr_due = (bytes_taken_reg == '0);
        blk_due = (block_left_reg == '0);

        // a length shrunk to or below what was taken opens a final block of one
        remain  = (eff_len > bytes_taken_reg) ? (eff_len - bytes_taken_reg)
                                              : zsse_pkg::LEN_W'(1);
        bfinal  = (remain <= zsse_pkg::LEN_W'(zsse_pkg::BLOCK_MAX));
        blk_len = bfinal ? remain[zsse_pkg::SUM_W-1:0] : zsse_pkg::BLOCK_MAX;

        // Adler-32: each sum stays below twice the modulus, one subtract suffices
        low_sum  = {1'b0, sum_low_reg} + {{(zsse_pkg::SUM_W+1-zsse_pkg::DATA_W){1'b0}},
                                           s_data_byte};
        low_mod  = (low_sum >= zsse_pkg::ADLER_MOD)
                   ? zsse_pkg::SUM_W'(low_sum - zsse_pkg::ADLER_MOD)
                   : low_sum[zsse_pkg::SUM_W-1:0];
        high_sum = {1'b0, sum_high_reg} + {1'b0, low_mod};
        high_mod = (high_sum >= zsse_pkg::ADLER_MOD)
                   ? zsse_pkg::SUM_W'(high_sum - zsse_pkg::ADLER_MOD)
                   : high_sum[zsse_pkg::SUM_W-1:0];

        taken_inc   = bytes_taken_reg + zsse_pkg::LEN_W'(1);
        stream_done = (taken_inc >= eff_len);

        new_mask = '0;
        new_mask[zsse_pkg::SLOT_CMF]     = hdr_due;
        new_mask[zsse_pkg::SLOT_FLG]     = hdr_due;
        new_mask[zsse_pkg::SLOT_BFINAL]  = blk_due;
        new_mask[zsse_pkg::SLOT_LEN_LO]  = blk_due;
        new_mask[zsse_pkg::SLOT_LEN_HI]  = blk_due;
        new_mask[zsse_pkg::SLOT_NLEN_LO] = blk_due;
        new_mask[zsse_pkg::SLOT_NLEN_HI] = blk_due;
        new_mask[zsse_pkg::SLOT_DATA]    = 1'b1;
        new_mask[zsse_pkg::SLOT_S2_HI]   = stream_done;
        new_mask[zsse_pkg::SLOT_S2_LO]   = stream_done;
        new_mask[zsse_pkg::SLOT_S1_HI]   = stream_done;
        new_mask[zsse_pkg::SLOT_S1_LO]   = stream_done;

        desc_next.bfinal   = bfinal;
        desc_next.blk_len  = blk_len;
        desc_next.data     = s_data_byte;
        desc_next.sum_high = high_mod;
        desc_next.sum_low  = low_mod;

        // advance the stream state, or drop back to reset values at its end
        if (stream_done) begin
            bytes_taken_next = '0;
            block_left_next  = '0;
            sum_low_next     = zsse_pkg::SUM_W'(1);
            sum_high_next    = '0;
        end else begin
            bytes_taken_next = taken_inc;
            block_left_next  = (blk_due ? blk_len : block_left_reg) - zsse_pkg::SUM_W'(1);
            sum_low_next     = low_mod;
            sum_high_next    = high_mod;
        end
    end

    // ------------------------------------------------------------------
    // Drain sequencer: pending slots as a bit mask, lowest goes first
    // ------------------------------------------------------------------
    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = out_free && (mask_reg != '0);
    assign low_bit   = mask_reg & (~mask_reg + NS'(1));
    assign last_slot = (mask_reg == low_bit);

    // take the next item as the current one hands over its last byte
    assign s_ready   = (mask_reg == '0) || (emit && last_slot);
    assign accept    = s_valid && s_ready;

    always_comb begin
        slot = zsse_pkg::SLOT_CMF;
        for (int i = NS - 1; i >= 0; i--) begin
            if (low_bit[i]) begin
                slot = zsse_pkg::slot_t'(i[3:0]);
            end
        end
    end

    always_comb begin
        unique case (slot)
            zsse_pkg::SLOT_CMF:     slot_byte = zsse_pkg::ZLIB_CMF;
            zsse_pkg::SLOT_FLG:     slot_byte = zsse_pkg::ZLIB_FLG;
            zsse_pkg::SLOT_BFINAL:  slot_byte = {{(zsse_pkg::DATA_W-1){1'b0}}, desc_reg.bfinal};
            zsse_pkg::SLOT_LEN_LO:  slot_byte = desc_reg.blk_len[7:0];
            zsse_pkg::SLOT_LEN_HI:  slot_byte = desc_reg.blk_len[15:8];
            zsse_pkg::SLOT_NLEN_LO: slot_byte = ~desc_reg.blk_len[7:0];
            zsse_pkg::SLOT_NLEN_HI: slot_byte = ~desc_reg.blk_len[15:8];
            zsse_pkg::SLOT_DATA:    slot_byte = desc_reg.data;
            zsse_pkg::SLOT_S2_HI:   slot_byte = desc_reg.sum_high[15:8];
            zsse_pkg::SLOT_S2_LO:   slot_byte = desc_reg.sum_high[7:0];
            zsse_pkg::SLOT_S1_HI:   slot_byte = desc_reg.sum_low[15:8];
            zsse_pkg::SLOT_S1_LO:   slot_byte = desc_reg.sum_low[7:0];
            default:                slot_byte = desc_reg.data;
        endcase
    end

    always_comb begin
        if (accept) begin
            mask_next = new_mask;
        end else if (emit) begin
            mask_next = mask_reg & ~low_bit;
        end else begin
            mask_next = mask_reg;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_taken_reg <= '0;
            block_left_reg  <= '0;
            sum_low_reg     <= zsse_pkg::SUM_W'(1);
            sum_high_reg    <= '0;
            mask_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (accept) begin
                bytes_taken_reg <= bytes_taken_next;
                block_left_reg  <= block_left_next;
                sum_low_reg     <= sum_low_next;
                sum_high_reg    <= sum_high_next;
            end
            mask_reg <= mask_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            desc_reg <= desc_next;
        end
        if (emit) begin
            m_out_byte_reg   <= slot_byte;
            m_run_last_reg   <= last_slot;
            m_stream_end_reg <= (slot == zsse_pkg::SLOT_S1_LO);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = m_out_byte_reg;
    assign m_run_last   = m_run_last_reg;
    assign m_stream_end = m_stream_end_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_stream_end) |-> m_run_last)
        else $error("stream end byte not marked as last of its run");

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        ($countones(mask_reg) > 1) |-> !s_ready)
        else $error("input taken while descriptor still has several bytes");

    a_desc_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (mask_reg != '0) && mask_reg[zsse_pkg::SLOT_DATA])
        else $error("accepted transaction left no data slot pending");

    a_sums_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, sum_low_reg} < zsse_pkg::ADLER_MOD)
        && ({1'b0, sum_high_reg} < zsse_pkg::ADLER_MOD))
        else $error("Adler sum out of range");

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the zlib stored-stream encoder unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Run limits.
    localparam int unsigned CYCLE_LIMIT     = 200_000;
    localparam int unsigned RANDOM_BYTES    = 260;
    localparam int unsigned PRESSURE_STREAM = 120;
    localparam int unsigned HOLD_CYCLES     = 200;
    localparam int unsigned REST_PERCENT    = 19;
    localparam int unsigned SETTLE          = 20;
    localparam int unsigned REPORT_MAX      = 10;

    // stream_length sits at register index 0, byte address 0x0
    localparam logic [zsse_pkg::PADDR_W-1:0] ADDR_STREAM_LENGTH =
        {zsse_pkg::REG_STREAM_LENGTH, 2'b00};

    // One output transaction as the block presents it.
    typedef struct packed {
        logic [zsse_pkg::DATA_W-1:0] out_byte;
        logic                        run_last;
        logic                        stream_end;
    } zlib_byte_t;

    // Directed table: either a length write or one raw byte, with an optional
    // typed-in count of output bytes and the last of them.
    typedef enum logic [1:0] {
        ROW_LENGTH = 2'd0,
        ROW_BYTE   = 2'd1
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [31:0] value;
        logic [3:0]  n_out;   // 0: no typed expectation, predictor only
        logic [7:0]  tail;
    } stim_row_t;

    localparam int unsigned N_ROWS = 25;

    stim_row_t directed_rows [N_ROWS] = '{
        // reset length of 1: every byte is a complete stream of twelve bytes
        '{ROW_BYTE,   32'h0000_0000, 4'd12, 8'h01},
        '{ROW_BYTE,   32'h0000_00FF, 4'd12, 8'h00},
        // zero length behaves as one
        '{ROW_LENGTH, 32'h0000_0000, 4'd0,  8'h00},
        '{ROW_BYTE,   32'h0000_0080, 4'd12, 8'h81},
        // largest length: non-final 65535-byte block, then shrink in mid-block
        '{ROW_LENGTH, 32'hFFFF_FFFF, 4'd0,  8'h00},
        '{ROW_BYTE,   32'h0000_0000, 4'd8,  8'h00},
        '{ROW_BYTE,   32'h0000_0055, 4'd1,  8'h55},
        '{ROW_LENGTH, 32'h0000_0002, 4'd0,  8'h00},
        '{ROW_BYTE,   32'h0000_00AA, 4'd5,  8'h00},
        // block header due while the length is not above the bytes taken
        '{ROW_LENGTH, 32'h0000_0002, 4'd0,  8'h00},
        '{ROW_BYTE,   32'h0000_0010, 4'd8,  8'h10},
        '{ROW_LENGTH, 32'h0000_0003, 4'd0,  8'h00},
        '{ROW_BYTE,   32'h0000_0020, 4'd1,  8'h20},
        '{ROW_LENGTH, 32'h0000_0001, 4'd0,  8'h00},
        '{ROW_BYTE,   32'h0000_0030, 4'd10, 8'h61},
        // growth after a final block header opens a further block
        '{ROW_LENGTH, 32'h0000_0002, 4'd0,  8'h00},
        '{ROW_BYTE,   32'h0000_0001, 4'd8,  8'h01},
        '{ROW_LENGTH, 32'h0000_0004, 4'd0,  8'h00},
        '{ROW_BYTE,   32'h0000_0002, 4'd1,  8'h02},
        '{ROW_BYTE,   32'h0000_0003, 4'd6,  8'h03},
        '{ROW_BYTE,   32'h0000_0004, 4'd5,  8'h0B},
        // a plain three-byte stream
        '{ROW_LENGTH, 32'h0000_0003, 4'd0,  8'h00},
        '{ROW_BYTE,   32'h0000_00FF, 4'd0,  8'h00},
        '{ROW_BYTE,   32'h0000_007F, 4'd0,  8'h00},
        '{ROW_BYTE,   32'h0000_0000, 4'd0,  8'h00}
    };

    // Clock, reset and every block input start at known values.
    logic                          aclk         = 1'b0;
    logic                          aresetn      = 1'b0;
    logic                          psel         = 1'b0;
    logic                          penable      = 1'b0;
    logic                          pwrite       = 1'b0;
    logic [zsse_pkg::PADDR_W-1:0]  paddr        = '0;
    logic [zsse_pkg::PDATA_W-1:0]  pwdata       = '0;
    logic [zsse_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;
    logic                          s_valid      = 1'b0;
    logic                          s_ready;
    logic [zsse_pkg::DATA_W-1:0]   s_data_byte  = '0;
    logic                          m_valid;
    logic                          m_ready      = 1'b0;
    logic [zsse_pkg::DATA_W-1:0]   m_out_byte;
    logic                          m_run_last;
    logic                          m_stream_end;

    // Bytes of the zlib stream still owed by the block, oldest first.
    zlib_byte_t zlib_bytes_due [$];

    // Own copy of the stream state and of the length register.
    logic [31:0]                cfg_length = 32'd1;
    logic [31:0]                raw_taken;
    logic [zsse_pkg::SUM_W-1:0] blk_remaining;
    logic [zsse_pkg::SUM_W-1:0] adler_a;
    logic [zsse_pkg::SUM_W-1:0] adler_b;

    int unsigned mismatches = 0;
    int unsigned cycles     = 0;
    bit          calm       = 1'b0;   // suppress random idling on both sides
    bit          hold_req   = 1'b0;   // ask the receiver for one long hold-off

    zlib_stored_stream_encoder_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_run_last   (m_run_last),
        .m_stream_end (m_stream_end)
    );

    // 10 ns clock.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Abandon the run if it overstays the limit.
    initial begin
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("zlib_stored_stream_encoder_unit: mismatch");
                $finish;
            end
        end
    end

    // Count every failure; report only the first few in full.
    function automatic void flag(input string msg);
        if (mismatches < REPORT_MAX)
            $display("[%0t] %s", $realtime, msg);
        mismatches++;
    endfunction

    function automatic bit rests();
        return !calm && ($urandom_range(99) < REST_PERCENT);
    endfunction

    // Return the stream state to its reset values.
    function automatic void restart_stream();
        raw_taken     = '0;
        blk_remaining = '0;
        adler_a       = 16'd1;
        adler_b       = '0;
    endfunction

    // Append one byte to the owed list.
    function automatic void owe_byte(input zlib_byte_t zb);
        zlib_bytes_due = {zlib_bytes_due, zb};
    endfunction

    // Work out the zlib bytes caused by one raw byte, queue them, and hand
    // back how many there were and the last of them.
    function automatic int wrap_raw_byte(input logic [7:0] b, output logic [7:0] tail);
        zlib_byte_t                 burst [zsse_pkg::NUM_SLOTS];
        int                         n;
        logic [31:0]                eff_len;
        logic [31:0]                remain;
        logic [31:0]                blk;
        logic [zsse_pkg::SUM_W-1:0] nblk;
        logic [31:0]                sum;
        n       = 0;
        eff_len = (cfg_length == 32'd0) ? 32'd1 : cfg_length;
        if (raw_taken == 32'd0) begin
            burst[n] = '{zsse_pkg::ZLIB_CMF, 1'b0, 1'b0}; n++;
            burst[n] = '{zsse_pkg::ZLIB_FLG, 1'b0, 1'b0}; n++;
        end
        if (blk_remaining == '0) begin
            // open a block; a length at or below the bytes taken opens a final block of one
            remain = (eff_len > raw_taken) ? eff_len - raw_taken : 32'd1;
            blk    = (remain < 32'(zsse_pkg::BLOCK_MAX)) ? remain
                                                         : 32'(zsse_pkg::BLOCK_MAX);
            nblk   = ~blk[zsse_pkg::SUM_W-1:0];
            burst[n] = '{{7'd0, remain <= 32'(zsse_pkg::BLOCK_MAX)}, 1'b0, 1'b0}; n++;
            burst[n] = '{blk[7:0], 1'b0, 1'b0};   n++;
            burst[n] = '{blk[15:8], 1'b0, 1'b0};  n++;
            burst[n] = '{nblk[7:0], 1'b0, 1'b0};  n++;
            burst[n] = '{nblk[15:8], 1'b0, 1'b0}; n++;
            blk_remaining = blk[zsse_pkg::SUM_W-1:0];
        end
        burst[n] = '{b, 1'b0, 1'b0}; n++;
        sum           = (32'(adler_a) + 32'(b)) % 32'(zsse_pkg::ADLER_MOD);
        adler_a       = sum[zsse_pkg::SUM_W-1:0];
        sum           = (32'(adler_b) + 32'(adler_a)) % 32'(zsse_pkg::ADLER_MOD);
        adler_b       = sum[zsse_pkg::SUM_W-1:0];
        raw_taken     = raw_taken + 32'd1;
        blk_remaining = blk_remaining - 16'd1;
        if (raw_taken >= eff_len) begin
            burst[n] = '{adler_b[15:8], 1'b0, 1'b0}; n++;
            burst[n] = '{adler_b[7:0], 1'b0, 1'b0};  n++;
            burst[n] = '{adler_a[15:8], 1'b0, 1'b0}; n++;
            burst[n] = '{adler_a[7:0], 1'b0, 1'b1};  n++;
            restart_stream();
        end
        burst[n-1].run_last = 1'b1;
        for (int k = 0; k < n; k++)
            owe_byte(burst[k]);
        tail = burst[n-1].out_byte;
        return n;
    endfunction

    // Offer one raw byte, idling first at random; return once the
    // transaction has gone through, at the rising edge that took it.
    task automatic offer_raw_byte(input logic [7:0] b, output int n, output logic [7:0] tail);
        @(negedge aclk);
        while (rests()) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        n = wrap_raw_byte(b, tail);
    endtask

    // Let the block drain: drop valid, wait for the last owed byte, then let
    // the pipeline settle.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (zlib_bytes_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Write stream_length over APB once idle, then read it back.
    task automatic program_length(input logic [31:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_STREAM_LENGTH;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        cfg_length = value;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== value)
            flag($sformatf("stream_length read back %08h, wrote %08h", prdata, value));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Receiver: random back-pressure, one long hold-off on request.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_ready  <= 1'b0;
            end else begin
                m_ready <= !rests();
            end
        end
    end

    // Compare every output transaction with the oldest owed byte.
    always @(posedge aclk) begin
        zlib_byte_t got;
        zlib_byte_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_out_byte, m_run_last, m_stream_end};
            if (zlib_bytes_due.size() == 0) begin
                flag($sformatf("unexpected output byte=%02h run_last=%b stream_end=%b",
                               got.out_byte, got.run_last, got.stream_end));
            end else begin
                want = zlib_bytes_due.pop_front();
                if (got !== want)
                    flag($sformatf({"expected byte=%02h run_last=%b stream_end=%b, ",
                                    "got byte=%02h run_last=%b stream_end=%b"},
                                   want.out_byte, want.run_last, want.stream_end,
                                   got.out_byte, got.run_last, got.stream_end));
            end
        end
    end

    // Stimulus: directed table, one stream under pressure, then random streams.
    initial begin
        int          n;
        logic [7:0]  tail;
        int unsigned random_bytes;
        int unsigned pick;
        int unsigned budget;
        logic [31:0] len;

        restart_stream();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Walk the table; typed rows also cross-check the predictor.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_LENGTH) begin
                program_length(directed_rows[i].value);
            end else begin
                offer_raw_byte(directed_rows[i].value[7:0], n, tail);
                if (directed_rows[i].n_out != 4'd0 &&
                    (n != int'(directed_rows[i].n_out) || tail != directed_rows[i].tail))
                    flag($sformatf({"row %0d: predicted %0d bytes ending %02h, ",
                                    "table says %0d ending %02h"},
                                   i, n, tail, directed_rows[i].n_out,
                                   directed_rows[i].tail));
            end
        end

        // Hold the receiver off at the start so the input backs up; keep both
        // sides free of idling for the whole stream.
        program_length(PRESSURE_STREAM);
        calm     = 1'b1;
        hold_req = 1'b1;
        for (int k = 0; k < PRESSURE_STREAM; k++)
            offer_raw_byte(8'($urandom_range(255)), n, tail);
        calm = 1'b0;

        // Random streams: mostly short, some zero, some long or huge that get
        // cut short by a later length write, with occasional grow or shrink.
        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES) begin
            pick = $urandom_range(99);
            if (pick < 70)
                len = $urandom_range(24, 1);
            else if (pick < 78)
                len = 32'd0;
            else if (pick < 88)
                len = $urandom_range(120, 25);
            else if (pick < 94)
                len = 32'hFFFF_FFFF;
            else
                len = $urandom;
            program_length(len);
            budget = $urandom_range(30, 1);
            forever begin
                pick = $urandom_range(99);
                offer_raw_byte((pick < 10) ? 8'h00 : (pick < 20) ? 8'hFF :
                               8'($urandom_range(255)), n, tail);
                random_bytes++;
                if (raw_taken == 32'd0)
                    break;
                budget--;
                if (budget == 0 || $urandom_range(99) < 5) begin
                    // move the end to just around the bytes already taken
                    program_length(($urandom_range(9) == 0) ? 32'd0 :
                                   raw_taken + $urandom_range(3));
                    budget = $urandom_range(30, 1);
                end
            end
        end

        // Wait out the last bytes, then give stray output a chance to show.
        drain();
        repeat (SETTLE) @(posedge aclk);
        if (zlib_bytes_due.size() != 0)
            flag($sformatf("%0d output bytes never arrived", zlib_bytes_due.size()));

        if (mismatches == 0)
            $display("zlib_stored_stream_encoder_unit: match");
        else
            $display("zlib_stored_stream_encoder_unit: mismatch");
        $finish;
    end

endmodule
